### sv/url_component_splitter_core_macros.svh
// ----------------------------------------------------------------------------
// URL component splitter assertion macros
// Concurrent check helpers; defining ASSERT_OFF compiles them away.
// ----------------------------------------------------------------------------
`ifndef URL_COMPONENT_SPLITTER_CORE_MACROS_SVH
`define URL_COMPONENT_SPLITTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication checked on every rising edge outside reset.
`define UCS_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("url splitter check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define UCS_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("url splitter check failed");

`else

`define UCS_ASSERT_IMP(name, clk, rst, ante, cons)
`define UCS_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

### sv/ucs_pkg.sv
// ----------------------------------------------------------------------------
// URL component splitter package
// Shared widths, character codes, byte classes and the queue item type.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int POS_W = 13;
  localparam logic [POS_W-1:0] MAX_LEN = 13'd4096;
  localparam int OUT_DATA_W = 96;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_HASH  = 8'h23;

  typedef enum logic [2:0] {
    CLS_OTHER,
    CLS_SLASH,
    CLS_COLON,
    CLS_QAMP,
    CLS_HASH
  } cls_t;

  typedef enum logic [2:0] {
    PH_PROTO,
    PH_HOST,
    PH_PATH,
    PH_QUERY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    cls_t cls;
    logic last;
  } item_t;

  // Reduces a byte to the only distinctions the scanner cares about.
  function automatic cls_t classify(input logic [7:0] c);
    cls_t r;
    r = CLS_OTHER;
    if (c == CH_SLASH) r = CLS_SLASH;
    else if (c == CH_COLON) r = CLS_COLON;
    else if (c == CH_QMARK || c == CH_AMP) r = CLS_QAMP;
    else if (c == CH_HASH) r = CLS_HASH;
    return r;
  endfunction

endpackage

### sv/ucs_front.sv
// ----------------------------------------------------------------------------
// URL component splitter front end
// Accepts bytes, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module ucs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [7:0]    s_tdata,   // [7:0] ch
  input  logic          s_tlast,
  output logic          q_valid,
  output ucs_pkg::item_t q_item,
  input  logic          q_pop
);
  import ucs_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  item_t      head;
  item_t      head_next;
  item_t      tail;
  item_t      tail_next;
  item_t      new_item;
  logic       push;

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = head;

  always_comb begin
    new_item.cls  = classify(s_tdata);
    new_item.last = s_tlast;
    head_next     = head;
    tail_next     = tail;
    count_next    = count;
    if (push && q_pop) begin
      if (count == 2'd1) begin
        head_next = new_item;
      end else begin
        head_next = tail;
        tail_next = new_item;
      end
    end else if (push) begin
      count_next = count + 2'd1;
      if (count == 2'd0) begin
        head_next = new_item;
      end else begin
        tail_next = new_item;
      end
    end else if (q_pop) begin
      count_next = count - 2'd1;
      head_next  = tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
    head <= head_next;
    tail <= tail_next;
  end

endmodule

### sv/ucs_back.sv
// ----------------------------------------------------------------------------
// URL component splitter back end
// Scans classified bytes and registers the offset set after the last byte.
// ----------------------------------------------------------------------------
module ucs_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_valid,
  input  ucs_pkg::item_t                   q_item,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ucs_pkg::OUT_DATA_W-1:0]   m_tdata,  // see top level
  output logic                             m_tuser   // [0] too_long
);
  import ucs_pkg::*;

  phase_t           phase, phase_next;
  logic [1:0]       sep_match, sep_match_next;
  logic [POS_W-1:0] pos, pos_next;
  logic             colon_seen, colon_seen_next;
  logic             overflow, overflow_next;
  logic [POS_W-1:0] proto_end, proto_end_next;
  logic [POS_W-1:0] port_pos, port_pos_next;
  logic [POS_W-1:0] origin_pos, origin_pos_next;
  logic [POS_W-1:0] path_pos, path_pos_next;
  logic [POS_W-1:0] query_pos, query_pos_next;
  logic             out_valid_next;
  logic [OUT_DATA_W-1:0] out_data_next;
  logic             out_user_next;

  logic             scan;
  logic             is_sep, is_qsep;
  logic             go_path, at_path, go_query, at_query;
  logic [POS_W-1:0] len, pe, hb, pb, oe, pa, qe;

  assign q_pop = q_valid && (!q_item.last || !m_tvalid || m_tready);

  always_comb begin
    phase_next      = phase;
    sep_match_next  = sep_match;
    pos_next        = pos;
    colon_seen_next = colon_seen;
    overflow_next   = overflow;
    proto_end_next  = proto_end;
    port_pos_next   = port_pos;
    origin_pos_next = origin_pos;
    path_pos_next   = path_pos;
    query_pos_next  = query_pos;
    out_valid_next  = m_tvalid && !m_tready;
    out_data_next   = m_tdata;
    out_user_next   = m_tuser;

    is_sep  = (q_item.cls == CLS_SLASH) || (q_item.cls == CLS_QAMP)
           || (q_item.cls == CLS_HASH);
    is_qsep = (q_item.cls == CLS_QAMP) || (q_item.cls == CLS_HASH);
    scan    = q_pop && (pos < MAX_LEN);

    // A separator may close several sections in the same byte.
    go_path  = (phase == PH_HOST) && is_sep;
    at_path  = go_path || (phase == PH_PATH);
    go_query = at_path && is_qsep;
    at_query = go_query || (phase == PH_QUERY);

    if (q_pop && !scan) begin
      overflow_next = 1'b1;
    end

    if (scan) begin
      pos_next = pos + 13'd1;
      if (phase == PH_PROTO) begin
        if (sep_match == 2'd2 && q_item.cls == CLS_SLASH) begin
          proto_end_next = pos - 13'd2;
          sep_match_next = 2'd0;
          phase_next     = PH_HOST;
        end else if (q_item.cls == CLS_COLON) begin
          sep_match_next = 2'd1;
        end else if (sep_match == 2'd1 && q_item.cls == CLS_SLASH) begin
          sep_match_next = 2'd2;
        end else begin
          sep_match_next = 2'd0;
        end
      end else begin
        if (phase == PH_HOST && !is_sep && q_item.cls == CLS_COLON && !colon_seen) begin
          colon_seen_next = 1'b1;
          port_pos_next   = pos;
        end
        if (go_path) begin
          origin_pos_next = pos;
          phase_next      = PH_PATH;
        end
        if (go_query) begin
          path_pos_next = pos;
          phase_next    = PH_QUERY;
        end
        if (at_query && q_item.cls == CLS_HASH) begin
          query_pos_next = pos;
          phase_next     = PH_DONE;
        end
      end
    end

    len = pos_next;
    pe  = (phase_next != PH_PROTO) ? proto_end_next : len;
    hb  = (phase_next != PH_PROTO) ? proto_end_next + 13'd3 : len;
    oe  = (phase_next >= PH_PATH) ? origin_pos_next : len;
    pa  = (phase_next >= PH_QUERY) ? path_pos_next : len;
    qe  = (phase_next >= PH_DONE) ? query_pos_next : len;
    pb  = colon_seen_next ? port_pos_next : oe;

    if (q_pop && q_item.last) begin
      out_valid_next  = 1'b1;
      out_data_next   = {5'd0, len, qe, pa, oe, pb, hb, pe};
      out_user_next   = overflow_next;
      phase_next      = PH_PROTO;
      sep_match_next  = 2'd0;
      pos_next        = '0;
      colon_seen_next = 1'b0;
      overflow_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_PROTO;
      sep_match  <= 2'd0;
      pos        <= '0;
      colon_seen <= 1'b0;
      overflow   <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      phase      <= phase_next;
      sep_match  <= sep_match_next;
      pos        <= pos_next;
      colon_seen <= colon_seen_next;
      overflow   <= overflow_next;
      m_tvalid   <= out_valid_next;
    end
    proto_end  <= proto_end_next;
    port_pos   <= port_pos_next;
    origin_pos <= origin_pos_next;
    path_pos   <= path_pos_next;
    query_pos  <= query_pos_next;
    m_tdata    <= out_data_next;
    m_tuser    <= out_user_next;
  end

endmodule

### sv/url_component_splitter_core.sv
// ----------------------------------------------------------------------------
// URL component splitter
// Splits a byte stream of URL text into protocol, host, port, path, query
// and fragment offsets.
// ----------------------------------------------------------------------------
// The block takes one URL byte per transaction on the input stream, with
// tlast on the final byte, and sustains one byte per clock while no final
// byte waits on an unclaimed result. After the final byte it emits one
// output transaction carrying seven 13-bit offsets and an overflow flag.
// The final byte is registered in the queue, scanned after any bytes still
// waiting ahead of it, and its result is registered by the scanner. Bytes
// pass first through a classifier and a two-entry queue, then through the
// scanner, which handles one byte per cycle when not stalled and owns the
// result register. A waiting result stalls the scanner only when the next
// URL's final byte reaches it, so input keeps flowing while the result sits
// unclaimed. Bytes past the 4096th of a URL are dropped unscanned and raise
// the too_long flag. No initialization pass is needed after reset.
module url_component_splitter_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,  // [7:0] ch
  input  logic                           s_tlast,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [12:0] protocol_end, [25:13] host_begin, [38:26] port_begin,
  // [51:39] origin_end, [64:52] path_end, [77:65] query_end,
  // [90:78] total_length, [95:91] zero
  output logic [ucs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic                           m_tuser   // [0] too_long
);
  import ucs_pkg::*;

  `include "url_component_splitter_core_macros.svh"

  // Queue between the classifier and the scanner.
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  ucs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  ucs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // A final byte must never overwrite a result that has not been taken.
  `UCS_ASSERT_IMP(a_no_result_overwrite, clk, rst, q_pop && q_item.last,
                  !m_tvalid || m_tready)

  // Every final byte the scanner consumes produces a result next cycle.
  `UCS_ASSERT_NXT(a_result_follows_last, clk, rst, q_pop && q_item.last,
                  m_tvalid)

  // The scanner only consumes entries the queue actually holds.
  `UCS_ASSERT_IMP(a_pop_needs_entry, clk, rst, q_pop, q_valid)

endmodule
